// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mep_pkg.sv -----
// Package with constants, register codes and the state type of the p-state search.
package mep_pkg;

	localparam int MAX_PSTATES_DEF = 16;

	// Configuration address width and register codes (word index of paddr).
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_PSTATE_COUNT   = 2'd0;
	localparam logic [1:0] REG_DEFAULT_PSTATE = 2'd1;
	localparam logic [1:0] REG_MAX_PENALTY    = 2'd2;

	localparam logic [4:0]  PSTATE_COUNT_RST   = 5'd16;
	localparam logic [3:0]  DEFAULT_PSTATE_RST = 4'd1;
	localparam logic [15:0] MAX_PENALTY_RST    = 16'd6554;

	localparam logic CMD_SAMPLE     = 1'b0;
	localparam logic CMD_LOOP_START = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RPREV,
		ST_MUL,
		ST_DEC
	} mep_state_t;

endpackage

// ----- hw/rtl/mep_if.sv -----
// Channel interfaces for sample items in and decision items out.
interface mep_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  current_pstate;
	logic [31:0] sample_time;
	logic [15:0] sample_power;

	modport source (output valid, cmd, current_pstate, sample_time, sample_power,
		input ready);
	modport sink (input valid, cmd, current_pstate, sample_time, sample_power,
		output ready);
endinterface

interface mep_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] target_pstate;
	logic       done_res;

	modport source (output valid, target_pstate, done_res, input ready);
	modport sink (input valid, target_pstate, done_res, output ready);
endinterface

// ----- hw/rtl/min_energy_pstate_search.sv -----
// Top level of the model-free minimum-energy p-state search.
//
// Items arrive on in_ch (valid/ready). A sample item (cmd low) stores the
// measured time and power for its p-state in a table RAM and marks the entry
// valid; it produces one decision item on out_ch: the next p-state and a done
// flag. A loop-start item (cmd high) clears the valid marks and produces no
// result; the block stays idle and ready for the next item.
// A sample item goes in steps from acceptance to a loaded output register:
// accept with the table write and the default entry read, the faster entry
// read, the 32x16 multiplies, and the decision. The single read port of the
// table puts the reads in turn; a new item is accepted only after the last is done.
// The output register holds a finished result until out_ch takes it; while it
// is full, a further sample waits in its decision step with in_ch.ready low.
// Configuration goes over an APB-style port (pready always high), to be written
// only while the block is idle; the block does not enforce this. Asynchronous
// reset clears the control state, the valid and written marks (unwritten table
// entries read as zero) and sets registers to defaults; no clearing pass is needed.
module min_energy_pstate_search #(
	parameter int MAX_PSTATES = mep_pkg::MAX_PSTATES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mep_in_if.sink                     in_ch,
	mep_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mep_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int IdxW = $clog2(MAX_PSTATES);
	localparam logic [4:0] CntLim = 5'((MAX_PSTATES < 16) ? MAX_PSTATES : 16);

	mep_pkg::mep_state_t state_q, state_d;

	logic [4:0]  cnt_q;
	logic [3:0]  dflt_q;
	logic [15:0] pen_q;

	logic [47:0] tbl_mem [MAX_PSTATES];
	logic [47:0] rdata_q;
	logic [IdxW-1:0] raddr_c;
	logic [MAX_PSTATES-1:0] wr_q;
	logic [MAX_PSTATES-1:0] vld_q;

	logic [4:0]  n_c;
	logic [3:0]  cur_c, def_c;
	logic        in_acc, smp_acc, clr_acc;

	logic [4:0]  item_n_q;
	logic [3:0]  item_cur_q, item_def_q;
	logic [31:0] item_t_q;
	logic [15:0] item_p_q;
	logic [3:0]  prev_c;

	logic [31:0] tref_q;
	logic        def_vld_q;
	logic [47:0] ecur_q, eprev_q, pen_prod_q;

	logic [48:0] limit_c;
	logic        under_c, ok_c;
	logic [4:0]  cur_inc_c;
	logic [3:0]  res_next_c;
	logic        res_done_c;

	logic        in_ready_c, dec_load_c;
	logic        out_valid_q, out_done_q;
	logic [3:0]  out_next_q;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= mep_pkg::PSTATE_COUNT_RST;
			dflt_q <= mep_pkg::DEFAULT_PSTATE_RST;
			pen_q  <= mep_pkg::MAX_PENALTY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				mep_pkg::REG_PSTATE_COUNT:   cnt_q  <= pwdata[4:0];
				mep_pkg::REG_DEFAULT_PSTATE: dflt_q <= pwdata[3:0];
				mep_pkg::REG_MAX_PENALTY:    pen_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mep_pkg::REG_PSTATE_COUNT:   prdata = {27'd0, cnt_q};
			mep_pkg::REG_DEFAULT_PSTATE: prdata = {28'd0, dflt_q};
			mep_pkg::REG_MAX_PENALTY:    prdata = {16'd0, pen_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// Count in use and clamped indices.
	always_comb begin
		if (cnt_q == 5'd0) begin
			n_c = 5'd1;
		end else if (cnt_q > CntLim) begin
			n_c = CntLim;
		end else begin
			n_c = cnt_q;
		end
		cur_c = ({1'b0, in_ch.current_pstate} >= n_c) ? 4'(n_c - 5'd1) : in_ch.current_pstate;
		def_c = ({1'b0, dflt_q} >= n_c) ? 4'(n_c - 5'd1) : dflt_q;
	end

	assign in_acc  = in_ch.valid && in_ready_c;
	assign smp_acc = in_acc && (in_ch.cmd == mep_pkg::CMD_SAMPLE);
	assign clr_acc = in_acc && (in_ch.cmd == mep_pkg::CMD_LOOP_START);
	assign prev_c  = item_cur_q - 4'd1;

	// Table RAM: written at acceptance, one registered read per cycle.
	assign raddr_c = (state_q == mep_pkg::ST_IDLE) ? IdxW'(def_c) : IdxW'(prev_c);

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			tbl_mem[IdxW'(cur_c)] <= {in_ch.sample_time, in_ch.sample_power};
		end
		rdata_q <= tbl_mem[raddr_c];
	end

	// Written marks stand for the all-zero reset of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			vld_q <= '0;
		end else if (clr_acc) begin
			vld_q <= '0;
		end else if (smp_acc) begin
			wr_q[IdxW'(cur_c)]  <= 1'b1;
			vld_q[IdxW'(cur_c)] <= 1'b1;
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			item_n_q   <= n_c;
			item_cur_q <= cur_c;
			item_def_q <= def_c;
			item_t_q   <= in_ch.sample_time;
			item_p_q   <= in_ch.sample_power;
		end
	end

	// Datapath: reference time, products.
	always_ff @(posedge clk) begin
		if (state_q == mep_pkg::ST_RPREV) begin
			// The default entry read at acceptance missed the same-cycle write.
			if (item_cur_q == item_def_q) begin
				tref_q <= item_t_q;
			end else if (wr_q[IdxW'(item_def_q)]) begin
				tref_q <= rdata_q[47:16];
			end else begin
				tref_q <= 32'd0;
			end
			def_vld_q <= vld_q[IdxW'(item_def_q)];
			ecur_q    <= 48'(item_t_q) * 48'(item_p_q);
		end
		if (state_q == mep_pkg::ST_MUL) begin
			if (wr_q[IdxW'(prev_c)]) begin
				eprev_q <= 48'(rdata_q[47:16]) * 48'(rdata_q[15:0]);
			end else begin
				eprev_q <= 48'd0;
			end
			pen_prod_q <= 48'(tref_q) * 48'(pen_q);
		end
	end

	// Decision.
	always_comb begin
		limit_c   = {1'b0, tref_q, 16'd0} + {1'b0, pen_prod_q};
		under_c   = {1'b0, item_t_q, 16'd0} < limit_c;
		ok_c      = (ecur_q <= eprev_q) && under_c;
		cur_inc_c = {1'b0, item_cur_q} + 5'd1;
		if (!def_vld_q) begin
			res_next_c = item_def_q;
			res_done_c = 1'b0;
		end else if ((item_cur_q > item_def_q) && !ok_c) begin
			res_next_c = prev_c;
			res_done_c = 1'b1;
		end else if (cur_inc_c < item_n_q) begin
			res_next_c = cur_inc_c[3:0];
			res_done_c = 1'b0;
		end else begin
			res_next_c = item_cur_q;
			res_done_c = 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mep_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mep_pkg::ST_IDLE: begin
				if (smp_acc) begin
					state_d = mep_pkg::ST_RPREV;
				end
			end
			mep_pkg::ST_RPREV: state_d = mep_pkg::ST_MUL;
			mep_pkg::ST_MUL:   state_d = mep_pkg::ST_DEC;
			mep_pkg::ST_DEC: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = mep_pkg::ST_IDLE;
				end
			end
			default: state_d = mep_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready_c = 1'b0;
		dec_load_c = 1'b0;
		unique case (state_q)
			mep_pkg::ST_IDLE:  in_ready_c = 1'b1;
			mep_pkg::ST_RPREV: ;
			mep_pkg::ST_MUL:   ;
			mep_pkg::ST_DEC:   dec_load_c = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	assign in_ch.ready = in_ready_c;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_load_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_load_c) begin
			out_next_q <= res_next_c;
			out_done_q <= res_done_c;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.target_pstate = out_next_q;
	assign out_ch.done_res      = out_done_q;

endmodule

// ----- hw/rtl/mep_checker.sv -----
// Port-level checker for the p-state search, bound to the top level.
`include "assert_macros.svh"

module mep_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_cmd,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] target_pstate,
	input logic       done_res
);

	`MEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MEP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(target_pstate) && $stable(done_res), "stalled result changed")
	`MEP_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && !in_cmd, !in_ready, "sample item did not occupy the block")
	`MEP_ASSERT_NEXT(a_clr_no_result, in_valid && in_ready && in_cmd && !out_valid, !out_valid, "loop start produced a result")

endmodule

bind min_energy_pstate_search mep_checker u_mep_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_cmd        (in_ch.cmd),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.target_pstate (out_ch.target_pstate),
	.done_res      (out_ch.done_res)
);

// ----- test/min_energy_pstate_search_test.sv -----
// Self-checking testbench for the minimum-energy p-state search block.
`timescale 1ns / 1ps

module min_energy_pstate_search_test;

	localparam int PSTATE_LIMIT = (mep_pkg::MAX_PSTATES_DEF < 16) ? mep_pkg::MAX_PSTATES_DEF : 16;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 135;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  pstate;
		logic [31:0] sample_time;
		logic [15:0] sample_power;
	} sample_item_t;

	typedef struct packed {
		logic [3:0] target_pstate;
		logic       done_res;
	} decision_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mep_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mep_in_if in_ch ();
	mep_out_if out_ch ();

	min_energy_pstate_search DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sample_item_t pending_samples[$];
	decision_t expected_decisions[$];

	// Shadow of the block's registers and measurement table.
	logic [4:0] cfg_count = mep_pkg::PSTATE_COUNT_RST;
	logic [3:0] cfg_default = mep_pkg::DEFAULT_PSTATE_RST;
	logic [15:0] cfg_penalty = mep_pkg::MAX_PENALTY_RST;
	logic [31:0] saved_time[16];
	logic [15:0] saved_power[16];
	logic saved_valid[16];

	int unsigned mismatches = 0;
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;
	int unsigned idle_cycles = 0;
	bit quiet_in = 0;
	bit quiet_out = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int unsigned draw_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic int unsigned count_now();
		int unsigned n;
		n = cfg_count;
		if (n < 1)
			n = 1;
		if (n > PSTATE_LIMIT)
			n = PSTATE_LIMIT;
		return n;
	endfunction

	function automatic decision_t advance_or_settle(input int unsigned cur, input int unsigned n);
		decision_t d;
		if (cur + 1 < n) begin
			d.target_pstate = 4'(cur + 1);
			d.done_res = 1'b0;
		end else begin
			d.target_pstate = 4'(cur);
			d.done_res = 1'b1;
		end
		return d;
	endfunction

	// Stores the sample in the shadow table and works out the decision.
	function automatic decision_t predict_decision(input sample_item_t it);
		int unsigned n, cur, def, faster;
		logic [63:0] tref, limit, e_now, e_faster, t_scaled;
		decision_t d;
		n = count_now();
		cur = (it.pstate >= n) ? n - 1 : it.pstate;
		def = (cfg_default >= n) ? n - 1 : cfg_default;
		saved_time[cur] = it.sample_time;
		saved_power[cur] = it.sample_power;
		saved_valid[cur] = 1'b1;
		if (!saved_valid[def]) begin
			d.target_pstate = 4'(def);
			d.done_res = 1'b0;
			return d;
		end
		tref = 64'(saved_time[def]);
		limit = (tref << 16) + tref * 64'(cfg_penalty);
		if (cur <= def)
			return advance_or_settle(cur, n);
		faster = cur - 1;
		e_now = 64'(it.sample_time) * 64'(it.sample_power);
		e_faster = 64'(saved_time[faster]) * 64'(saved_power[faster]);
		t_scaled = 64'(it.sample_time) << 16;
		if (e_now <= e_faster && t_scaled < limit)
			return advance_or_settle(cur, n);
		d.target_pstate = 4'(faster);
		d.done_res = 1'b1;
		return d;
	endfunction

	// Sample driver: one item per handshake, random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		sample_item_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.cmd <= mep_pkg::CMD_SAMPLE;
			in_ch.current_pstate <= '0;
			in_ch.sample_time <= '0;
			in_ch.sample_power <= '0;
			in_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.cmd == mep_pkg::CMD_LOOP_START) begin
					foreach (saved_valid[i])
						saved_valid[i] = 1'b0;
				end else begin
					it.cmd = in_ch.cmd;
					it.pstate = in_ch.current_pstate;
					it.sample_time = in_ch.sample_time;
					it.sample_power = in_ch.sample_power;
					expected_decisions.push_back(predict_decision(it));
				end
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_ch.valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending_samples.size() > 0) begin
					it = pending_samples.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.cmd <= it.cmd;
					in_ch.current_pstate <= it.pstate;
					in_ch.sample_time <= it.sample_time;
					in_ch.sample_power <= it.sample_power;
					in_gap <= draw_gap(quiet_in);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Decision monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		decision_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_decisions.size() == 0) begin
					report_mismatch($sformatf("unexpected decision target_pstate=%0d done_res=%0d",
						out_ch.target_pstate, out_ch.done_res));
				end else begin
					want = expected_decisions.pop_front();
					if (out_ch.target_pstate !== want.target_pstate)
						report_mismatch($sformatf("target_pstate got %0d want %0d",
							out_ch.target_pstate, want.target_pstate));
					if (out_ch.done_res !== want.done_res)
						report_mismatch($sformatf("done_res got %0d want %0d",
							out_ch.done_res, want.done_res));
				end
			end
			if (out_stall > 0) begin
				out_ch.ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				out_stall <= draw_gap(quiet_out);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_register(input logic [1:0] code, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {code, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (code)
			mep_pkg::REG_PSTATE_COUNT: cfg_count = value[4:0];
			mep_pkg::REG_DEFAULT_PSTATE: cfg_default = value[3:0];
			mep_pkg::REG_MAX_PENALTY: cfg_penalty = value[15:0];
			default: ;
		endcase
	endtask

	// Upper bits of each written word are random; only the register width counts.
	task automatic set_search_config(input logic [4:0] count, input logic [3:0] def,
			input logic [15:0] penalty);
		write_register(mep_pkg::REG_PSTATE_COUNT, {27'($urandom), count});
		write_register(mep_pkg::REG_DEFAULT_PSTATE, {28'($urandom), def});
		write_register(mep_pkg::REG_MAX_PENALTY, {16'($urandom), penalty});
	endtask

	// Waits until every item has been sent and every decision has come back.
	task automatic drain_block();
		do
			@(negedge clk);
		while (pending_samples.size() > 0 || in_ch.valid || expected_decisions.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_sample(input int unsigned ps, input logic [31:0] t,
			input logic [15:0] p);
		pending_samples.push_back('{mep_pkg::CMD_SAMPLE, 4'(ps), t, p});
	endfunction

	function automatic void push_loop_start();
		pending_samples.push_back('{mep_pkg::CMD_LOOP_START, 4'($urandom), $urandom,
			16'($urandom)});
	endfunction

	function automatic logic [31:0] draw_time();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom;
		if (r < 8)
			return $urandom_range(100, 2000000);
		return $urandom_range(0, 15);
	endfunction

	// A search run: mostly a loop start, at times a lower state, the default state, then slower states in order.
	function automatic int unsigned push_search_run();
		int unsigned n, def, last, pushed;
		logic [63:0] t, pw;
		pushed = 0;
		n = count_now();
		def = (cfg_default >= n) ? n - 1 : cfg_default;
		if ($urandom_range(0, 7) != 0) begin
			push_loop_start();
			pushed++;
		end
		t = 64'(draw_time());
		pw = 64'($urandom_range(1, 65535));
		if (def > 0 && $urandom_range(0, 4) == 0) begin
			push_sample($urandom_range(0, def - 1), draw_time(), 16'($urandom));
			pushed++;
		end
		push_sample(def, t[31:0], pw[15:0]);
		pushed++;
		last = $urandom_range(def + 1, 16);
		for (int unsigned k = def + 1; k <= last && k <= 15; k++) begin
			t = t + (t >> 5) * $urandom_range(0, 5);
			if (t > 64'hFFFF_FFFF)
				t = 64'hFFFF_FFFF;
			if ($urandom_range(0, 5) == 0)
				pw = pw + $urandom_range(0, 2000);
			else
				pw = pw * $urandom_range(70, 100) / 100;
			if (pw > 64'hFFFF)
				pw = 64'hFFFF;
			push_sample(k, t[31:0], pw[15:0]);
			pushed++;
		end
		return pushed;
	endfunction

	task automatic run_random_phase(input int unsigned budget);
		int unsigned pushed;
		pushed = 0;
		quiet_in = ($urandom_range(0, 3) == 0);
		quiet_out = ($urandom_range(0, 3) == 0);
		while (pushed < budget) begin
			if ($urandom_range(0, 9) < 7) begin
				pushed += push_search_run();
			end else begin
				if ($urandom_range(0, 9) == 0)
					push_loop_start();
				else
					push_sample($urandom_range(0, 15), draw_time(), 16'($urandom));
				pushed++;
			end
		end
		drain_block();
	endtask

	initial begin
		foreach (saved_valid[i]) begin
			saved_time[i] = '0;
			saved_power[i] = '0;
			saved_valid[i] = 1'b0;
		end
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: 16 states, default 1, penalty near 0.1.
		push_sample(5, 32'd500, 16'd10);         // default not yet measured
		push_sample(0, 32'd700, 16'd20);         // below default, default still unknown
		push_sample(1, 32'd1000, 16'd100);       // default measured, step onward
		push_sample(0, 32'd800, 16'd90);         // below default acts as default
		push_sample(2, 32'd900, 16'd100);        // lower energy, under the limit
		push_sample(3, 32'd1200, 16'd50);        // lower energy but too slow
		push_sample(3, 32'd1050, 16'd80);        // lower energy, just under the limit
		push_sample(4, 32'd1050, 16'd90);        // higher energy settles back
		push_sample(5, 32'd1050, 16'd90);        // equal energy still steps on
		push_sample(15, 32'd0, 16'd0);           // last state with zero sample settles
		push_sample(15, 32'hFFFF_FFFF, 16'hFFFF);
		push_sample(14, 32'hFFFF_FFFF, 16'hFFFF);
		push_loop_start();
		push_sample(2, 32'd100, 16'd1);          // default cleared by loop start
		push_sample(1, 32'd65536, 16'd1000);     // limit becomes exactly 72090 << 16
		push_sample(2, 32'd72090, 16'd10);       // time equal to the limit fails
		push_sample(2, 32'd72089, 16'd10);       // one below the limit passes
		push_sample(1, 32'hFFFF_FFFF, 16'hFFFF); // largest default time and power
		push_sample(2, 32'hFFFF_FFFF, 16'hFFFF);
		push_loop_start();
		push_loop_start();
		push_sample(1, 32'h5555_AAAA, 16'hA5A5);
		push_sample(3, 32'h0000_0001, 16'h0001); // faster entry left from earlier loop
		drain_block();

		set_search_config(5'd16, 4'd0, 16'd0);
		run_random_phase(PHASE_ITEMS);
		set_search_config(5'd1, 4'd15, 16'hFFFF);
		run_random_phase(PHASE_ITEMS);
		set_search_config(5'd31, 4'd15, 16'hFFFF);
		run_random_phase(PHASE_ITEMS);
		set_search_config(5'd0, 4'd3, 16'd6554);
		run_random_phase(PHASE_ITEMS);
		repeat (3) begin
			set_search_config(5'($urandom_range(2, 16)), 4'($urandom), 16'($urandom));
			run_random_phase(PHASE_ITEMS);
		end

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mep_pkg.sv
hw/rtl/mep_if.sv
hw/rtl/min_energy_pstate_search.sv
hw/rtl/mep_checker.sv
test/min_energy_pstate_search_test.sv
